// File: sv/dcc_pkg.sv
// Shared types and constants for the dual circular convolution core.
// No dependencies; used by the input and result interfaces, the cell, the control and the top level.
`default_nettype none
package dcc_pkg;

  localparam int WINDOW_LEN = 64;
  localparam int SAMPLE_W   = 16;
  localparam int PROD_W     = 2 * SAMPLE_W;
  localparam int ACC_W      = 44;
  localparam int IDX_W      = $clog2(WINDOW_LEN);
  localparam int CNT_W      = $clog2(WINDOW_LEN + 1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  // per-cycle commands broadcast to every cell of the ring
  typedef struct packed {
    logic load;       // shift new samples in from the tail
    logic rotate;     // a ring rotates up, b/c chain moves toward the head
    logic mul_en;     // capture the products
    logic acc_first;  // accumulator takes the product
    logic acc_en;     // accumulator adds the product
    logic drain;      // accumulators move one place toward the head
  } cell_ctrl_t;

endpackage
`default_nettype wire

// File: sv/dcc_in_if.sv
// Input channel: one sample of each of a, b and c per transaction.
// Depends on dcc_pkg.
`default_nettype none
interface dcc_in_if;
  logic              valid;
  logic              ready;
  dcc_pkg::sample_t  a_sample;
  dcc_pkg::sample_t  b_sample;
  dcc_pkg::sample_t  c_sample;

  modport source (output valid, output a_sample, output b_sample, output c_sample,
                  input ready);
  modport sink   (input valid, input a_sample, input b_sample, input c_sample,
                  output ready);
endinterface
`default_nettype wire

// File: sv/dcc_out_if.sv
// Result channel: one pair of convolution values per transaction.
// Depends on dcc_pkg.
`default_nettype none
interface dcc_out_if;
  logic           valid;
  logic           ready;
  dcc_pkg::acc_t  ab_value;
  dcc_pkg::acc_t  ac_value;
  logic           last_out;

  modport source (output valid, output ab_value, output ac_value, output last_out,
                  input ready);
  modport sink   (input valid, input ab_value, input ac_value, input last_out,
                  output ready);
endinterface
`default_nettype wire

// File: sv/dcc_cfg_if.sv
// Configuration write channel: carries the normalize_enable bit.
// No dependencies.
`default_nettype none
interface dcc_cfg_if;
  logic valid;
  logic ready;
  logic normalize_enable;

  modport source (output valid, output normalize_enable, input ready);
  modport sink   (input valid, input normalize_enable, output ready);
endinterface
`default_nettype wire

// File: sv/dual_circular_convolution_core.sv
// Dual circular convolution core: computes a(*)b and a(*)c over a window of
// WINDOW_LEN samples. Depends on dcc_pkg, the channel interfaces, dcc_cell, dcc_ctrl.
//
// Usage:
//  - in_ch carries one sample of a, b and c per transaction. After WINDOW_LEN
//    transactions the window is complete and the ring computes.
//  - out_ch then gives WINDOW_LEN transactions, index 0 first; last_out marks
//    the final one of the run.
//  - cfg_ch writes normalize_enable (1: plain convolution, 0: WINDOW_LEN times
//    it); cfg_ch.ready is high outside reset. Write it only while the block is idle.
// Flow:
//  - Samples are taken one per cycle while in_ch.ready is high. Closing the window
//    starts the compute steps in the ring of WINDOW_LEN multiply-accumulate cells;
//    no sample is taken during them, and the first result is valid once they end.
//  - Results drain from the head cell one per cycle while the receiver is ready
//    and while the next window loads.
//  - When the receiver stalls, results hold; loading continues except for the
//    sample that would close the next window.
//  - Reset clears the sample count and pending results and sets normalize_enable.
`default_nettype none
module dual_circular_convolution_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  dcc_in_if.sink     in_ch,
  dcc_out_if.source  out_ch,
  dcc_cfg_if.sink    cfg_ch
);

  localparam int N = dcc_pkg::WINDOW_LEN;
  localparam logic [dcc_pkg::ACC_W-1:0] WIN_SCALE = dcc_pkg::ACC_W'(dcc_pkg::WINDOW_LEN);

  dcc_pkg::cell_ctrl_t ctrl;
  dcc_pkg::sample_t    a_q  [N];
  dcc_pkg::sample_t    b_q  [N];
  dcc_pkg::sample_t    c_q  [N];
  dcc_pkg::acc_t       ab_q [N];
  dcc_pkg::acc_t       ac_q [N];
  dcc_pkg::sample_t    a_rt [N];
  dcc_pkg::sample_t    b_rt [N];
  dcc_pkg::sample_t    c_rt [N];
  dcc_pkg::acc_t       ab_rt[N];
  dcc_pkg::acc_t       ac_rt[N];
  logic                norm_r;

  assign cfg_ch.ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_r <= 1'b1;
    end else if (cfg_ch.valid) begin
      norm_r <= cfg_ch.normalize_enable;
    end
  end

  dcc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .last_out  (out_ch.last_out),
    .ctrl      (ctrl)
  );

  for (genvar j = 0; j < N; j++) begin : g_cell
    if (j == N - 1) begin : g_tail
      assign a_rt[j]  = in_ch.a_sample;
      assign b_rt[j]  = in_ch.b_sample;
      assign c_rt[j]  = in_ch.c_sample;
      assign ab_rt[j] = '0;
      assign ac_rt[j] = '0;
    end else begin : g_body
      assign a_rt[j]  = a_q[j+1];
      assign b_rt[j]  = b_q[j+1];
      assign c_rt[j]  = c_q[j+1];
      assign ab_rt[j] = ab_q[j+1];
      assign ac_rt[j] = ac_q[j+1];
    end

    dcc_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .a_left   (a_q[(j + N - 1) % N]),
      .a_right  (a_rt[j]),
      .b_right  (b_rt[j]),
      .c_right  (c_rt[j]),
      .b_head   (b_q[0]),
      .c_head   (c_q[0]),
      .ab_right (ab_rt[j]),
      .ac_right (ac_rt[j]),
      .a_q      (a_q[j]),
      .b_q      (b_q[j]),
      .c_q      (c_q[j]),
      .ab_q     (ab_q[j]),
      .ac_q     (ac_q[j])
    );
  end

  // unnormalized output is the window length times the sum, wrapped to 44 bits
  assign out_ch.ab_value = norm_r ? ab_q[0] : dcc_pkg::acc_t'(ab_q[0] * WIN_SCALE);
  assign out_ch.ac_value = norm_r ? ac_q[0] : dcc_pkg::acc_t'(ac_q[0] * WIN_SCALE);

endmodule
`default_nettype wire

// File: sv/dcc_cell.sv
// One cell of the convolution ring: holds a, b, c samples, two product
// registers and two accumulators. Depends on dcc_pkg.
`default_nettype none
module dcc_cell (
  input  wire logic                clk,
  input  wire dcc_pkg::cell_ctrl_t ctrl,
  input  wire dcc_pkg::sample_t    a_left,
  input  wire dcc_pkg::sample_t    a_right,
  input  wire dcc_pkg::sample_t    b_right,
  input  wire dcc_pkg::sample_t    c_right,
  input  wire dcc_pkg::sample_t    b_head,
  input  wire dcc_pkg::sample_t    c_head,
  input  wire dcc_pkg::acc_t       ab_right,
  input  wire dcc_pkg::acc_t       ac_right,
  output dcc_pkg::sample_t         a_q,
  output dcc_pkg::sample_t         b_q,
  output dcc_pkg::sample_t         c_q,
  output dcc_pkg::acc_t            ab_q,
  output dcc_pkg::acc_t            ac_q
);

  dcc_pkg::sample_t a_r, a_nxt, b_r, b_nxt, c_r, c_nxt;
  dcc_pkg::prod_t   pab_r, pab_nxt, pac_r, pac_nxt;
  dcc_pkg::acc_t    ab_r, ab_nxt, ac_r, ac_nxt;
  dcc_pkg::acc_t    pab_ext, pac_ext;

  assign pab_ext = dcc_pkg::acc_t'(pab_r);
  assign pac_ext = dcc_pkg::acc_t'(pac_r);

  always_comb begin
    a_nxt   = a_r;
    b_nxt   = b_r;
    c_nxt   = c_r;
    pab_nxt = pab_r;
    pac_nxt = pac_r;
    ab_nxt  = ab_r;
    ac_nxt  = ac_r;
    if (ctrl.load) begin
      a_nxt = a_right;
    end else if (ctrl.rotate) begin
      a_nxt = a_left;
    end
    if (ctrl.load || ctrl.rotate) begin
      b_nxt = b_right;
      c_nxt = c_right;
    end
    if (ctrl.mul_en) begin
      pab_nxt = a_r * b_head;
      pac_nxt = a_r * c_head;
    end
    if (ctrl.acc_first) begin
      ab_nxt = pab_ext;
      ac_nxt = pac_ext;
    end else if (ctrl.acc_en) begin
      ab_nxt = ab_r + pab_ext;
      ac_nxt = ac_r + pac_ext;
    end else if (ctrl.drain) begin
      ab_nxt = ab_right;
      ac_nxt = ac_right;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    c_r   <= c_nxt;
    pab_r <= pab_nxt;
    pac_r <= pac_nxt;
    ab_r  <= ab_nxt;
    ac_r  <= ac_nxt;
  end

  assign a_q  = a_r;
  assign b_q  = b_r;
  assign c_q  = c_r;
  assign ab_q = ab_r;
  assign ac_q = ac_r;

endmodule
`default_nettype wire

// File: sv/dcc_ctrl.sv
// Sequencer of the convolution ring: load count, compute steps, result drain.
// Depends on dcc_pkg.
`default_nettype none
module dcc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          out_ready,
  output logic               in_ready,
  output logic               out_valid,
  output logic               last_out,
  output dcc_pkg::cell_ctrl_t ctrl
);

  typedef enum logic {ST_FILL, ST_CALC} state_t;

  localparam logic [dcc_pkg::IDX_W-1:0] LAST_SLOT = dcc_pkg::IDX_W'(dcc_pkg::WINDOW_LEN - 1);
  localparam logic [dcc_pkg::CNT_W-1:0] STEPS     = dcc_pkg::CNT_W'(dcc_pkg::WINDOW_LEN);

  state_t                     state_r, state_nxt;
  logic [dcc_pkg::IDX_W-1:0]  load_cnt_r, load_cnt_nxt;
  logic [dcc_pkg::CNT_W-1:0]  step_r, step_nxt;
  logic [dcc_pkg::CNT_W-1:0]  drain_cnt_r, drain_cnt_nxt;
  logic                       in_fire, out_fire, calc;

  assign calc      = (state_r == ST_CALC);
  assign out_valid = (drain_cnt_r != '0);
  assign last_out  = (drain_cnt_r == dcc_pkg::CNT_W'(1));
  // the window-closing sample waits until the previous results are gone
  assign in_ready  = rst_n && !calc && !((load_cnt_r == LAST_SLOT) && out_valid);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  always_comb begin
    state_nxt     = state_r;
    load_cnt_nxt  = load_cnt_r;
    step_nxt      = step_r;
    drain_cnt_nxt = drain_cnt_r;
    ctrl          = '0;
    ctrl.load     = in_fire;
    ctrl.drain    = out_fire;
    if (out_fire) begin
      drain_cnt_nxt = drain_cnt_r - dcc_pkg::CNT_W'(1);
    end
    case (state_r)
      ST_FILL: begin
        if (in_fire) begin
          if (load_cnt_r == LAST_SLOT) begin
            load_cnt_nxt = '0;
            step_nxt     = '0;
            state_nxt    = ST_CALC;
          end else begin
            load_cnt_nxt = load_cnt_r + dcc_pkg::IDX_W'(1);
          end
        end
      end
      ST_CALC: begin
        ctrl.mul_en    = (step_r != STEPS);
        ctrl.rotate    = (step_r != STEPS);
        ctrl.acc_first = (step_r == dcc_pkg::CNT_W'(1));
        ctrl.acc_en    = (step_r > dcc_pkg::CNT_W'(1));
        step_nxt       = step_r + dcc_pkg::CNT_W'(1);
        if (step_r == STEPS) begin
          drain_cnt_nxt = STEPS;
          state_nxt     = ST_FILL;
        end
      end
      default: begin
        state_nxt = ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      load_cnt_r  <= '0;
      step_r      <= '0;
      drain_cnt_r <= '0;
    end else begin
      state_r     <= state_nxt;
      load_cnt_r  <= load_cnt_nxt;
      step_r      <= step_nxt;
      drain_cnt_r <= drain_cnt_nxt;
    end
  end

endmodule
`default_nettype wire
